>>> rtl/efam_pkg.sv
// Package for the elevator fault alarm monitor: register indexes, codes,
// configuration and alarm structs. No dependencies.
`default_nettype none

package efam_pkg;

	// Default widths handed to the top level parameters
	localparam int AGE_WIDTH_DEF      = 16;
	localparam int RUN_TIME_WIDTH_DEF = 16;
	localparam int FLOOR_WIDTH_DEF    = 8;

	// Configuration write channel
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MODE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_TIMEOUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOOR_TIMEOUT_S   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRAP_TIMEOUT_MIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HOLD_S     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_HOLD_S  = 3'd7;

	// Request kinds
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Run status codes
	localparam logic [1:0] ST_LEVEL = 2'd0;
	localparam logic [1:0] ST_UP    = 2'd1;
	localparam logic [1:0] ST_DOWN  = 2'd2;

	// Limit modes; the fourth code acts like the checked mode
	localparam logic [1:0] LM_OFF       = 2'd0;
	localparam logic [1:0] LM_CHECK     = 2'd1;
	localparam logic [1:0] LM_AS_DOOR   = 2'd2;
	localparam logic [1:0] LM_CHECK_ALT = 2'd3;

	// check_enable bits
	localparam int CE_DOOR     = 0;
	localparam int CE_PRESENCE = 1;

	localparam int STUCK_DIV   = 10;
	localparam int SEC_PER_MIN = 60;

	typedef struct packed {
		logic [1:0]  check_enable;
		logic [1:0]  limit_mode;
		logic [12:0] stuck_timeout;
		logic [15:0] door_timeout_s;
		logic [15:0] speed_threshold;
		logic [9:0]  trap_timeout_min;
		logic [15:0] limit_hold_s;
		logic [15:0] presence_hold_s;
	} cfg_t;

	typedef struct packed {
		logic any_alarm;
		logic stuck_alarm;
		logic top_overrun;
		logic bottom_overrun;
		logic door_while_moving;
		logic overspeed;
		logic door_not_opened;
		logic trapped;
	} alarm_t;

endpackage

`default_nettype wire

>>> rtl/efam_if.sv
// Channel interfaces of the elevator fault alarm monitor: request, result
// and configuration write. Depends on efam_pkg.
`default_nettype none

interface efam_req_if #(
	parameter int RUN_TIME_WIDTH = efam_pkg::RUN_TIME_WIDTH_DEF,
	parameter int FLOOR_WIDTH    = efam_pkg::FLOOR_WIDTH_DEF
);
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [1:0]                run_status;
	logic [RUN_TIME_WIDTH-1:0] run_time;
	logic [FLOOR_WIDTH-1:0]    floor_index;
	logic                      limit_hit;
	logic                      door_open;
	logic                      level_sensor;
	logic                      person_seen;

	modport source (
		output valid, action, run_status, run_time, floor_index,
		       limit_hit, door_open, level_sensor, person_seen,
		input  ready
	);
	modport sink (
		input  valid, action, run_status, run_time, floor_index,
		       limit_hit, door_open, level_sensor, person_seen,
		output ready
	);
endinterface

interface efam_res_if;
	logic valid;
	logic ready;
	logic any_alarm;
	logic stuck_alarm;
	logic top_overrun;
	logic bottom_overrun;
	logic door_while_moving;
	logic overspeed;
	logic door_not_opened;
	logic trapped;

	modport source (
		output valid, any_alarm, stuck_alarm, top_overrun, bottom_overrun,
		       door_while_moving, overspeed, door_not_opened, trapped,
		input  ready
	);
	modport sink (
		input  valid, any_alarm, stuck_alarm, top_overrun, bottom_overrun,
		       door_while_moving, overspeed, door_not_opened, trapped,
		output ready
	);
endinterface

interface efam_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [efam_pkg::CFG_IDX_W-1:0]  index;
	logic [efam_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/efam_cfg.sv
// Configuration register bank of the elevator fault alarm monitor.
// Depends on efam_pkg and efam_cfg_if.
`default_nettype none

module efam_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	efam_cfg_if.sink          cfg,
	output efam_pkg::cfg_t    regs
);

	efam_pkg::cfg_t regs_q;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				efam_pkg::REG_CHECK_ENABLE:     regs_q.check_enable     <= cfg.data[1:0];
				efam_pkg::REG_LIMIT_MODE:       regs_q.limit_mode       <= cfg.data[1:0];
				efam_pkg::REG_STUCK_TIMEOUT:    regs_q.stuck_timeout    <= cfg.data[12:0];
				efam_pkg::REG_DOOR_TIMEOUT_S:   regs_q.door_timeout_s   <= cfg.data;
				efam_pkg::REG_SPEED_THRESHOLD:  regs_q.speed_threshold  <= cfg.data;
				efam_pkg::REG_TRAP_TIMEOUT_MIN: regs_q.trap_timeout_min <= cfg.data[9:0];
				efam_pkg::REG_LIMIT_HOLD_S:     regs_q.limit_hold_s     <= cfg.data;
				efam_pkg::REG_PRESENCE_HOLD_S:  regs_q.presence_hold_s  <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/efam_core.sv
// Alarm evaluation and history state of the elevator fault alarm monitor.
// Depends on efam_pkg.
`default_nettype none

module efam_core #(
	parameter int AGE_WIDTH      = efam_pkg::AGE_WIDTH_DEF,
	parameter int RUN_TIME_WIDTH = efam_pkg::RUN_TIME_WIDTH_DEF,
	parameter int FLOOR_WIDTH    = efam_pkg::FLOOR_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire efam_pkg::cfg_t            regs,
	input  wire logic                      go,
	input  wire logic                      action,
	input  wire logic [1:0]                run_status,
	input  wire logic [RUN_TIME_WIDTH-1:0] run_time,
	input  wire logic [FLOOR_WIDTH-1:0]    floor_index,
	input  wire logic                      limit_hit,
	input  wire logic                      door_open,
	input  wire logic                      level_sensor,
	input  wire logic                      person_seen,
	output efam_pkg::alarm_t               alarms
);

	localparam int STK_W  = $bits(regs.stuck_timeout) + 4;
	localparam int STK_CW = (RUN_TIME_WIDTH > STK_W) ? RUN_TIME_WIDTH : STK_W;
	localparam int SPD_CW = (RUN_TIME_WIDTH > 16) ? RUN_TIME_WIDTH : 16;
	localparam int AGE_CW = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

	logic                      started_q;
	logic [FLOOR_WIDTH-1:0]    prev_floor_q;
	logic [1:0]                prev_status_q;
	logic [RUN_TIME_WIDTH-1:0] prev_run_time_q;
	logic                      overspeed_q;
	logic                      door_seen_q;
	logic [AGE_WIDTH-1:0]      up_age_q, down_age_q, pres_age_q, trap_age_q, stop_age_q;

	logic                      overspeed_d, door_seen_d;
	logic [AGE_WIDTH-1:0]      up_age_d, down_age_d, pres_age_d, trap_age_d, stop_age_d;

	logic                      door_e, limit_e, lim_on, person_e;
	logic [FLOOR_WIDTH-1:0]    pf;
	logic [1:0]                ps;
	logic [RUN_TIME_WIDTH-1:0] prt;
	logic [STK_CW-1:0]         stuck_lim;
	logic [AGE_CW-1:0]         trap_lim;
	logic                      stuck, top, bottom, rundoor, nodoor, trapped;

	function automatic logic [AGE_WIDTH-1:0] age_inc(input logic [AGE_WIDTH-1:0] a);
		return (&a) ? a : a + AGE_WIDTH'(1);
	endfunction

	// run_time / 10 >= t  <=>  run_time >= 10 * t
	assign stuck_lim = STK_CW'(regs.stuck_timeout) * STK_CW'(efam_pkg::STUCK_DIV);
	assign trap_lim  = AGE_CW'(regs.trap_timeout_min) * AGE_CW'(efam_pkg::SEC_PER_MIN);

	always_comb begin
		overspeed_d = overspeed_q;
		door_seen_d = door_seen_q;
		up_age_d    = up_age_q;
		down_age_d  = down_age_q;
		pres_age_d  = pres_age_q;
		trap_age_d  = trap_age_q;
		stop_age_d  = stop_age_q;
		stuck       = 1'b0;
		top         = 1'b0;
		bottom      = 1'b0;
		rundoor     = 1'b0;
		nodoor      = 1'b0;
		trapped     = 1'b0;
		person_e    = person_seen;

		// limit sensor doubles as a door contact in that mode
		door_e  = door_open | ((regs.limit_mode == efam_pkg::LM_AS_DOOR) & ~limit_hit);
		limit_e = limit_hit & (regs.limit_mode != efam_pkg::LM_AS_DOOR);
		lim_on  = (regs.limit_mode == efam_pkg::LM_CHECK) ||
		          (regs.limit_mode == efam_pkg::LM_CHECK_ALT);

		// first sample is its own history
		pf  = started_q ? prev_floor_q    : floor_index;
		ps  = started_q ? prev_status_q   : run_status;
		prt = started_q ? prev_run_time_q : run_time;

		if (action == efam_pkg::ACT_TICK) begin
			up_age_d   = age_inc(up_age_q);
			down_age_d = age_inc(down_age_q);
			pres_age_d = age_inc(pres_age_q);
			trap_age_d = age_inc(trap_age_q);
			stop_age_d = age_inc(stop_age_q);
		end else begin
			stuck = (run_status != efam_pkg::ST_LEVEL) &&
			        (STK_CW'(run_time) >= stuck_lim);

			if (lim_on) begin
				if (limit_e && run_status == efam_pkg::ST_UP)
					up_age_d = '0;
				if (limit_e && run_status == efam_pkg::ST_DOWN)
					down_age_d = '0;
				top    = AGE_CW'(up_age_d) < AGE_CW'(regs.limit_hold_s);
				bottom = AGE_CW'(down_age_d) < AGE_CW'(regs.limit_hold_s);
			end

			rundoor = regs.check_enable[efam_pkg::CE_DOOR] &&
			          (run_status != efam_pkg::ST_LEVEL) && door_e && !level_sensor;

			if (floor_index == pf) begin
				if (run_status == efam_pkg::ST_LEVEL ||
				    SPD_CW'(run_time) > SPD_CW'(regs.speed_threshold))
					overspeed_d = 1'b0;
			end else if (run_status == efam_pkg::ST_LEVEL) begin
				overspeed_d = 1'b0;
			end else if (SPD_CW'(prt) < SPD_CW'(regs.speed_threshold)) begin
				overspeed_d = 1'b1;
			end

			if (regs.check_enable[efam_pkg::CE_DOOR] && run_status == efam_pkg::ST_LEVEL) begin
				if (ps != efam_pkg::ST_LEVEL) begin
					stop_age_d  = '0;
					door_seen_d = 1'b0;
				end else if (door_e) begin
					door_seen_d = 1'b1;
				end else if (AGE_CW'(stop_age_q) >= AGE_CW'(regs.door_timeout_s) &&
				             !door_seen_q) begin
					nodoor = 1'b1;
				end
			end

			if (regs.check_enable[efam_pkg::CE_PRESENCE]) begin
				if (person_seen)
					pres_age_d = '0;
				if (AGE_CW'(pres_age_d) < AGE_CW'(regs.presence_hold_s))
					person_e = 1'b1;
				if ((run_status == efam_pkg::ST_LEVEL && door_e) || !person_e)
					trap_age_d = '0;
				else if (AGE_CW'(trap_age_q) >= trap_lim)
					trapped = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q       <= 1'b0;
			prev_floor_q    <= '0;
			prev_status_q   <= '0;
			prev_run_time_q <= '0;
			overspeed_q     <= 1'b0;
			door_seen_q     <= 1'b1;
			up_age_q        <= '1;
			down_age_q      <= '1;
			pres_age_q      <= '1;
			trap_age_q      <= '0;
			stop_age_q      <= '0;
		end else if (go) begin
			overspeed_q <= overspeed_d;
			door_seen_q <= door_seen_d;
			up_age_q    <= up_age_d;
			down_age_q  <= down_age_d;
			pres_age_q  <= pres_age_d;
			trap_age_q  <= trap_age_d;
			stop_age_q  <= stop_age_d;
			if (action == efam_pkg::ACT_SAMPLE) begin
				started_q       <= 1'b1;
				prev_floor_q    <= floor_index;
				prev_status_q   <= run_status;
				prev_run_time_q <= run_time;
			end
		end
	end

	assign alarms.stuck_alarm       = stuck;
	assign alarms.top_overrun       = top;
	assign alarms.bottom_overrun    = bottom;
	assign alarms.door_while_moving = rundoor;
	assign alarms.overspeed         = overspeed_d;
	assign alarms.door_not_opened   = nodoor;
	assign alarms.trapped           = trapped;
	assign alarms.any_alarm         = stuck | top | bottom | rundoor | overspeed_d |
	                                  nodoor | trapped;

endmodule

`default_nettype wire

>>> rtl/elevator_fault_alarm_monitor.sv
// Top level of the elevator fault alarm monitor: input register, alarm core,
// result register. Depends on efam_pkg, efam_if, efam_cfg and efam_core.
//
// Usage:
//  - req_in carries requests: a status sample (action 0) or a one-second
//    tick (action 1). A sample yields exactly one result on res_out; a tick
//    only advances the saturating age counters and yields nothing.
//  - res_out carries the seven alarm flags and their OR.
//  - cfg_in writes the configuration registers (index = register number);
//    it is always ready. Write only while no request is in flight.
// Timing:
//  - A request is registered on acceptance and evaluated from the input
//    register against the history state; a sample's result then lands in the
//    output register, which raises res_out.valid, once that register is free or draining.
//  - One request per cycle sustained while res_out does not stall; the input
//    register and the output register decouple the two sides, so a new
//    request is taken while a result waits to be collected.
//  - When res_out stalls, a pending sample holds in the input register and
//    req_in.ready drops; pending ticks still pass since they give no result.
// Reset (arst_n low): registers cleared, limit and presence ages saturated,
//  history marked empty so the first sample serves as its own predecessor.
`default_nettype none

module elevator_fault_alarm_monitor #(
	parameter int AGE_WIDTH      = efam_pkg::AGE_WIDTH_DEF,
	parameter int RUN_TIME_WIDTH = efam_pkg::RUN_TIME_WIDTH_DEF,
	parameter int FLOOR_WIDTH    = efam_pkg::FLOOR_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	efam_req_if.sink   req_in,
	efam_res_if.source res_out,
	efam_cfg_if.sink   cfg_in
);

	efam_pkg::cfg_t   regs;
	efam_pkg::alarm_t alarms;
	efam_pkg::alarm_t alarms_q;

	// Input stage
	logic                      valid_s1;
	logic                      action_s1;
	logic [1:0]                run_status_s1;
	logic [RUN_TIME_WIDTH-1:0] run_time_s1;
	logic [FLOOR_WIDTH-1:0]    floor_index_s1;
	logic                      limit_hit_s1, door_open_s1, level_sensor_s1, person_seen_s1;

	logic res_valid_q;
	logic s1_go;
	logic req_take;

	efam_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_in),
		.regs   (regs)
	);

	// Ticks never need the output register; samples need it free or draining
	assign s1_go        = valid_s1 && (action_s1 == efam_pkg::ACT_TICK ||
	                                   !res_valid_q || res_out.ready);
	assign req_in.ready = !valid_s1 || s1_go;
	assign req_take     = req_in.valid && req_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_in.ready)
			valid_s1 <= req_in.valid;
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			action_s1       <= req_in.action;
			run_status_s1   <= req_in.run_status;
			run_time_s1     <= req_in.run_time;
			floor_index_s1  <= req_in.floor_index;
			limit_hit_s1    <= req_in.limit_hit;
			door_open_s1    <= req_in.door_open;
			level_sensor_s1 <= req_in.level_sensor;
			person_seen_s1  <= req_in.person_seen;
		end
	end

	efam_core #(
		.AGE_WIDTH      (AGE_WIDTH),
		.RUN_TIME_WIDTH (RUN_TIME_WIDTH),
		.FLOOR_WIDTH    (FLOOR_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.regs         (regs),
		.go           (s1_go),
		.action       (action_s1),
		.run_status   (run_status_s1),
		.run_time     (run_time_s1),
		.floor_index  (floor_index_s1),
		.limit_hit    (limit_hit_s1),
		.door_open    (door_open_s1),
		.level_sensor (level_sensor_s1),
		.person_seen  (person_seen_s1),
		.alarms       (alarms)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && action_s1 == efam_pkg::ACT_SAMPLE) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && action_s1 == efam_pkg::ACT_SAMPLE)
			alarms_q <= alarms;
	end

	assign res_out.valid             = res_valid_q;
	assign res_out.any_alarm         = alarms_q.any_alarm;
	assign res_out.stuck_alarm       = alarms_q.stuck_alarm;
	assign res_out.top_overrun       = alarms_q.top_overrun;
	assign res_out.bottom_overrun    = alarms_q.bottom_overrun;
	assign res_out.door_while_moving = alarms_q.door_while_moving;
	assign res_out.overspeed         = alarms_q.overspeed;
	assign res_out.door_not_opened   = alarms_q.door_not_opened;
	assign res_out.trapped           = alarms_q.trapped;

endmodule

`default_nettype wire

>>> tb/sv/tb_elevator_fault_alarm_monitor.sv
// Self-checking bench for elevator_fault_alarm_monitor: random and directed requests,
// randomized back-pressure, in-order result checking against a behavioral predictor.
// Depends on efam_pkg, efam_if and the RTL of the monitor.
`timescale 1ns / 1ps

module tb_elevator_fault_alarm_monitor;
	import efam_pkg::*;

	// Run status 3 is legal on the wire: not level, neither up nor down.
	localparam logic [1:0] ST_OTHER  = 2'd3;
	localparam int         TOP_FLOOR = 15;
	localparam int         CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic        action;
		logic [1:0]  run_status;
		logic [15:0] run_time;
		logic [7:0]  floor_index;
		logic        limit_hit;
		logic        door_open;
		logic        level_sensor;
		logic        person_seen;
	} elev_req_t;

	// Alarm tracker: own copy of config and history, one expected alarm set per
	// accepted sample, checked in order against what comes out.
	class alarm_tracker;
		cfg_t        cfg;
		bit          started;
		logic [7:0]  prev_floor;
		logic [1:0]  prev_status;
		logic [15:0] prev_run_time;
		bit          overspeed_latch;
		bit          door_seen;
		logic [15:0] up_age, down_age, presence_age, trap_age, stop_age;
		alarm_t      expected_alarms[$];
		int          fail_count;

		function new();
			cfg = '0;
			started = 1'b0;
			prev_floor = '0;
			prev_status = ST_LEVEL;
			prev_run_time = '0;
			overspeed_latch = 1'b0;
			door_seen = 1'b1;
			up_age = '1;
			down_age = '1;
			presence_age = '1;
			trap_age = '0;
			stop_age = '0;
			fail_count = 0;
		endfunction

		function logic [15:0] aged(logic [15:0] a);
			return (a == '1) ? a : a + 16'd1;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CHECK_ENABLE:     cfg.check_enable     = data[1:0];
				REG_LIMIT_MODE:       cfg.limit_mode       = data[1:0];
				REG_STUCK_TIMEOUT:    cfg.stuck_timeout    = data[12:0];
				REG_DOOR_TIMEOUT_S:   cfg.door_timeout_s   = data;
				REG_SPEED_THRESHOLD:  cfg.speed_threshold  = data;
				REG_TRAP_TIMEOUT_MIN: cfg.trap_timeout_min = data[9:0];
				REG_LIMIT_HOLD_S:     cfg.limit_hold_s     = data;
				REG_PRESENCE_HOLD_S:  cfg.presence_hold_s  = data;
				default: ;
			endcase
		endfunction

		function void take_request(elev_req_t r);
			logic [1:0] st;
			logic       lim, door, person;
			alarm_t     a;
			if (r.action == ACT_TICK) begin
				up_age = aged(up_age);
				down_age = aged(down_age);
				presence_age = aged(presence_age);
				trap_age = aged(trap_age);
				stop_age = aged(stop_age);
				return;
			end
			st = r.run_status;
			lim = r.limit_hit;
			door = r.door_open;
			person = r.person_seen;
			a = '0;
			// limit sensor doubles as a second door contact
			if (cfg.limit_mode == LM_AS_DOOR) begin
				door = door | ~lim;
				lim = 1'b0;
			end
			// first sample is its own predecessor
			if (!started) begin
				prev_floor = r.floor_index;
				prev_status = st;
				prev_run_time = r.run_time;
				started = 1'b1;
			end
			if (st != ST_LEVEL && (r.run_time / STUCK_DIV) >= cfg.stuck_timeout)
				a.stuck_alarm = 1'b1;
			if (cfg.limit_mode == LM_CHECK || cfg.limit_mode == LM_CHECK_ALT) begin
				if (lim && st == ST_UP) up_age = '0;
				if (up_age < cfg.limit_hold_s) a.top_overrun = 1'b1;
				if (lim && st == ST_DOWN) down_age = '0;
				if (down_age < cfg.limit_hold_s) a.bottom_overrun = 1'b1;
			end
			if (cfg.check_enable[CE_DOOR] && st != ST_LEVEL && door && !r.level_sensor)
				a.door_while_moving = 1'b1;
			// overspeed latch is evaluated whatever the enables say
			if (r.floor_index == prev_floor) begin
				if (st == ST_LEVEL || r.run_time > cfg.speed_threshold)
					overspeed_latch = 1'b0;
			end else if (st == ST_LEVEL) begin
				overspeed_latch = 1'b0;
			end else if (prev_run_time < cfg.speed_threshold) begin
				overspeed_latch = 1'b1;
			end
			if (cfg.check_enable[CE_DOOR] && st == ST_LEVEL) begin
				if (prev_status != ST_LEVEL) begin
					stop_age = '0;
					door_seen = 1'b0;
				end else if (door) begin
					door_seen = 1'b1;
				end else if (stop_age >= cfg.door_timeout_s && !door_seen) begin
					a.door_not_opened = 1'b1;
				end
			end
			if (cfg.check_enable[CE_PRESENCE]) begin
				if (person) presence_age = '0;
				if (presence_age < cfg.presence_hold_s) person = 1'b1;
				if ((st == ST_LEVEL && door) || !person)
					trap_age = '0;
				else if (int'(trap_age) >= int'(cfg.trap_timeout_min) * SEC_PER_MIN)
					a.trapped = 1'b1;
			end
			prev_floor = r.floor_index;
			prev_status = st;
			prev_run_time = r.run_time;
			a.overspeed = overspeed_latch;
			a.any_alarm = a.stuck_alarm | a.top_overrun | a.bottom_overrun |
				a.door_while_moving | a.overspeed | a.door_not_opened | a.trapped;
			expected_alarms.push_back(a);
		endfunction

		function void check_alarms(alarm_t got);
			alarm_t want;
			string  names[8];
			names = '{"any_alarm", "stuck_alarm", "top_overrun", "bottom_overrun",
				"door_while_moving", "overspeed", "door_not_opened", "trapped"};
			if (expected_alarms.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %b", $time, got);
				fail_count++;
				return;
			end
			want = expected_alarms.pop_front();
			for (int i = 0; i < 8; i++) begin
				if (got[7-i] !== want[7-i]) begin
					$display("%0t: %s expected %0b, got %0b", $time, names[i],
						want[7-i], got[7-i]);
					fail_count++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	efam_req_if req_ch();
	efam_res_if res_ch();
	efam_cfg_if cfg_ch();

	elevator_fault_alarm_monitor i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_in  (req_ch),
		.res_out (res_ch),
		.cfg_in  (cfg_ch)
	);

	alarm_tracker sb = new();

	always #10 clk = ~clk;

	// Watchdog: any hang or lost result ends here.
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("elevator_fault_alarm_monitor: mismatch");
			$finish;
		end
	end

	// Result monitor: handshake sampled with pre-edge values.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_alarms({res_ch.any_alarm, res_ch.stuck_alarm, res_ch.top_overrun,
				res_ch.bottom_overrun, res_ch.door_while_moving, res_ch.overspeed,
				res_ch.door_not_opened, res_ch.trapped});
	end

	// Result sink back-pressure. Mostly short stalls, some long ones, calm stretches,
	// and a long hold-off on request from the stimulus (counted here, in cycles).
	int rx_hold_req = 0;
	int rx_stall = 0;
	int rx_calm = 0;
	initial begin
		int pick;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				rx_stall = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				res_ch.ready <= 1'b0;
			end else if (rx_calm > 0) begin
				rx_calm--;
				res_ch.ready <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					rx_calm = $urandom_range(20, 60);
					res_ch.ready <= 1'b1;
				end else if (pick < 65) begin
					res_ch.ready <= 1'b1;
				end else begin
					res_ch.ready <= 1'b0;
					rx_stall = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	function automatic elev_req_t mk(logic act, logic [1:0] st, logic [15:0] rt,
		logic [7:0] fl, logic lim, logic door, logic lvl, logic per);
		return '{act, st, rt, fl, lim, door, lvl, per};
	endfunction

	function automatic cfg_t mk_cfg(logic [1:0] ce, logic [1:0] lm, logic [12:0] stuck,
		logic [15:0] door_to, logic [15:0] speed, logic [9:0] trap, logic [15:0] hold,
		logic [15:0] pres);
		return '{ce, lm, stuck, door_to, speed, trap, hold, pres};
	endfunction

	// Fully random request; every field bit gets both values over the run.
	function automatic elev_req_t rand_item();
		elev_req_t r;
		r.action = 1'($urandom_range(0, 1));
		r.run_status = 2'($urandom_range(0, 3));
		r.run_time = 16'($urandom);
		r.floor_index = 8'($urandom);
		r.limit_hit = 1'($urandom_range(0, 1));
		r.door_open = 1'($urandom_range(0, 1));
		r.level_sensor = 1'($urandom_range(0, 1));
		r.person_seen = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic elev_req_t tick_item();
		elev_req_t r;
		r = rand_item();
		r.action = ACT_TICK;
		return r;
	endfunction

	// Plausible car motion: dwell at a floor with door activity, then a run of
	// a few floors with growing run time, then stop again.
	logic [1:0] trip_status = ST_LEVEL;
	int         trip_floor = 0;
	int         trip_rt = 0;
	int         trip_left = 3;
	logic       trip_door = 1'b0;
	logic       trip_person = 1'b0;

	function automatic elev_req_t next_trip();
		elev_req_t r;
		logic      near_floor;
		if ($urandom_range(0, 99) < 30)
			return tick_item();
		near_floor = 1'b0;
		if (trip_status == ST_LEVEL) begin
			trip_rt = trip_rt + $urandom_range(1, 20);
			if ($urandom_range(0, 3) == 0) trip_door = ~trip_door;
			trip_left--;
			if (trip_left == 0) begin
				if (trip_floor == 0) trip_status = ST_UP;
				else if (trip_floor >= TOP_FLOOR) trip_status = ST_DOWN;
				else trip_status = $urandom_range(0, 1) ? ST_UP : ST_DOWN;
				trip_rt = 0;
				trip_door = 1'b0;
				trip_left = $urandom_range(2, 8);
			end
		end else begin
			trip_rt = trip_rt + $urandom_range(1, 40);
			if ($urandom_range(0, 99) < 35) begin
				if (trip_status == ST_UP && trip_floor < TOP_FLOOR) trip_floor++;
				if (trip_status == ST_DOWN && trip_floor > 0) trip_floor--;
				near_floor = 1'b1;
			end
			trip_left--;
			if (trip_left == 0) begin
				trip_status = ST_LEVEL;
				trip_rt = 0;
				trip_left = $urandom_range(1, 6);
			end
		end
		if (trip_rt > 65535) trip_rt = 65535;
		if ($urandom_range(0, 9) == 0) trip_person = ~trip_person;
		r.action = ACT_SAMPLE;
		r.run_status = ($urandom_range(0, 49) == 0) ? ST_OTHER : trip_status;
		r.run_time = trip_rt[15:0];
		r.floor_index = trip_floor[7:0];
		r.person_seen = trip_person;
		if (trip_status == ST_LEVEL) begin
			r.door_open = trip_door;
			r.level_sensor = ($urandom_range(0, 19) != 0);
		end else begin
			r.door_open = ($urandom_range(0, 19) == 0);
			r.level_sensor = near_floor;
		end
		// end-of-travel sensor mostly at the terminal floors
		if ((trip_status == ST_UP && trip_floor == TOP_FLOOR) ||
			(trip_status == ST_DOWN && trip_floor == 0))
			r.limit_hit = 1'($urandom_range(0, 1));
		else
			r.limit_hit = ($urandom_range(0, 19) == 0);
		return r;
	endfunction

	// Present one request and hold it until the handshake; call at a clock edge.
	task automatic send_request(elev_req_t r);
		req_ch.valid <= 1'b1;
		req_ch.action <= r.action;
		req_ch.run_status <= r.run_status;
		req_ch.run_time <= r.run_time;
		req_ch.floor_index <= r.floor_index;
		req_ch.limit_hit <= r.limit_hit;
		req_ch.door_open <= r.door_open;
		req_ch.level_sensor <= r.level_sensor;
		req_ch.person_seen <= r.person_seen;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.take_request(r);
	endtask

	int tx_calm = 0;
	task automatic idle_gap();
		int pick, n;
		pick = $urandom_range(0, 99);
		if (tx_calm > 0) begin
			tx_calm--;
			n = 0;
		end else if (pick < 3) begin
			tx_calm = $urandom_range(20, 50);
			n = 0;
		end else if (pick < 60) begin
			n = 0;
		end else if (pick < 92) begin
			n = $urandom_range(1, 3);
		end else begin
			n = $urandom_range(6, 30);
		end
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending until every expected result is back, then let any tick
	// still in the pipeline clear, with margin.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.expected_alarms.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(cfg_t c);
		logic [CFG_IDX_W-1:0]  regs[8];
		logic [CFG_DATA_W-1:0] vals[8];
		regs = '{REG_CHECK_ENABLE, REG_LIMIT_MODE, REG_STUCK_TIMEOUT, REG_DOOR_TIMEOUT_S,
			REG_SPEED_THRESHOLD, REG_TRAP_TIMEOUT_MIN, REG_LIMIT_HOLD_S, REG_PRESENCE_HOLD_S};
		vals = '{16'(c.check_enable), 16'(c.limit_mode), 16'(c.stuck_timeout),
			c.door_timeout_s, c.speed_threshold, 16'(c.trap_timeout_min),
			c.limit_hold_s, c.presence_hold_s};
		for (int i = 0; i < 8; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[i];
			cfg_ch.data <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic cfg_t phase_cfg(int p);
		case (p)
			0: return mk_cfg(2'd3, LM_CHECK, 13'd20, 16'd4, 16'd15, 10'd0, 16'd3, 16'd5);
			// 16-bit registers at all ones, stuck and trap timeouts near their usable top
			1: return mk_cfg(2'd3, LM_CHECK_ALT, 13'd6553, 16'hFFFF, 16'hFFFF, 10'd1000,
				16'hFFFF, 16'hFFFF);
			2: return mk_cfg(2'd0, LM_OFF, 13'd0, 16'd0, 16'd0, 10'd0, 16'd0, 16'd0);
			3: return mk_cfg(2'd1, LM_AS_DOOR, 13'd8, 16'd1, 16'd40, 10'd0, 16'd2, 16'd0);
			// one-minute trap timeout, reached by long tick runs
			4: return mk_cfg(2'd2, LM_CHECK, 13'd3, 16'd0, 16'd0, 10'd1, 16'd1, 16'd2);
			default: return mk_cfg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				13'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 6553) :
					$urandom_range(0, 40)),
				16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)),
				10'($urandom_range(0, 2)),
				16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)));
		endcase
	endfunction

	task automatic run_phase(bit pressure);
		elev_req_t r;
		for (int i = 0; i < 55; i++) begin
			if (pressure && i == 50) begin
				// long sink hold-off while samples keep coming: input must back up
				rx_hold_req = 300;
				repeat (30) begin
					r = rand_item();
					r.action = ACT_SAMPLE;
					send_request(r);
				end
				drain();
			end else if ($urandom_range(0, 99) < 2) begin
				// a minute and more of seconds with nothing else happening
				repeat (65) send_request(tick_item());
			end else begin
				idle_gap();
				send_request(($urandom_range(0, 99) < 20) ? rand_item() : next_trip());
			end
		end
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		elev_req_t dir_a[$], dir_b[$], dir_c[$];
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_SAMPLE;
		req_ch.run_status <= ST_LEVEL;
		req_ch.run_time <= '0;
		req_ch.floor_index <= '0;
		req_ch.limit_hit <= 1'b0;
		req_ch.door_open <= 1'b0;
		req_ch.level_sensor <= 1'b0;
		req_ch.person_seen <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_CHECK_ENABLE;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Door checks on, speed threshold set, the rest at reset values.
		// The first sample must compare against itself: same floor, no overspeed.
		dir_a = '{
			mk(ACT_SAMPLE, ST_UP, 16'd5, 8'd9, 1'b0, 1'b0, 1'b0, 1'b0),
			mk(ACT_SAMPLE, ST_LEVEL, 16'd0, 8'd9, 1'b0, 1'b0, 1'b1, 1'b0),  // stop
			mk(ACT_SAMPLE, ST_LEVEL, 16'd3, 8'd9, 1'b0, 1'b0, 1'b1, 1'b0),  // door shut
			mk(ACT_SAMPLE, ST_LEVEL, 16'd4, 8'd9, 1'b0, 1'b1, 1'b1, 1'b0),  // door opens
			mk(ACT_SAMPLE, ST_UP, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1), // run time and floor all ones
			mk(ACT_TICK, ST_OTHER, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1), // tick
			mk(ACT_SAMPLE, ST_DOWN, 16'd0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0),   // floor jump
			mk(ACT_SAMPLE, ST_OTHER, 16'd12345, 8'd128, 1'b0, 1'b1, 1'b0, 1'b1),
			mk(ACT_SAMPLE, ST_UP, 16'd20, 8'd128, 1'b0, 1'b1, 1'b1, 1'b0)   // at level
		};
		write_config(mk_cfg(2'd1, LM_OFF, 13'd0, 16'd0, 16'd100, 10'd0, 16'd0, 16'd0));
		foreach (dir_a[i]) send_request(dir_a[i]);
		drain();

		// Limit checked with a short hold, stuck at the largest timeout a 16-bit run time reaches, instant trap.
		dir_b = '{
			mk(ACT_SAMPLE, ST_UP, 16'd100, 8'd3, 1'b1, 1'b0, 1'b0, 1'b0),   // top overrun
			mk(ACT_TICK, ST_LEVEL, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0),
			mk(ACT_SAMPLE, ST_DOWN, 16'd100, 8'd3, 1'b1, 1'b0, 1'b0, 1'b0), // bottom too
			mk(ACT_TICK, ST_LEVEL, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0),
			mk(ACT_TICK, ST_LEVEL, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0),
			mk(ACT_SAMPLE, ST_DOWN, 16'hFFFF, 8'd2, 1'b0, 1'b0, 1'b0, 1'b0), // stuck
			mk(ACT_SAMPLE, ST_LEVEL, 16'd0, 8'd2, 1'b0, 1'b0, 1'b1, 1'b1),  // person
			mk(ACT_TICK, ST_LEVEL, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0),
			mk(ACT_SAMPLE, ST_LEVEL, 16'd0, 8'd2, 1'b0, 1'b0, 1'b1, 1'b0)   // hold over
		};
		write_config(mk_cfg(2'd3, LM_CHECK, 13'd6553, 16'd2, 16'hFFFF, 10'd0, 16'd2, 16'd1));
		foreach (dir_b[i]) send_request(dir_b[i]);
		drain();

		// Limit sensor as second door: clear sensor means door open.
		dir_c = '{
			mk(ACT_SAMPLE, ST_UP, 16'd10, 8'd2, 1'b0, 1'b0, 1'b0, 1'b0),
			mk(ACT_SAMPLE, ST_UP, 16'd10, 8'd2, 1'b1, 1'b0, 1'b0, 1'b0)
		};
		write_config(mk_cfg(2'd3, LM_AS_DOOR, 13'd1, 16'd0, 16'd5, 10'd0, 16'd4, 16'd0));
		foreach (dir_c[i]) send_request(dir_c[i]);

		// Random phases, each under its own configuration.
		for (int p = 0; p < 8; p++) begin
			drain();
			write_config(phase_cfg(p));
			run_phase(p == 3);
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.fail_count == 0 && sb.expected_alarms.size() == 0)
			$display("elevator_fault_alarm_monitor: match");
		else
			$display("elevator_fault_alarm_monitor: mismatch");
		$finish;
	end

endmodule
